/* hdl/flash_erase_program_planner_unit_macros.svh */
// Assertion macros for the flash erase and program planner.
// Used by the checker file; depends on nothing else.
`ifndef FLASH_ERASE_PROGRAM_PLANNER_UNIT_MACROS_SVH
`define FLASH_ERASE_PROGRAM_PLANNER_UNIT_MACROS_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define FEPP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define FEPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/fepp_pkg.sv */
// Shared types and constants of the flash erase and program planner.
// Used by every module of the block; depends on nothing.
package fepp_pkg;

    localparam int DEF_ADDR_BITS = 24;
    localparam int START_W = 24;
    localparam int LEN_W = 25;
    localparam int OPC_W = 8;
    localparam int OPB_W = 9;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    localparam logic [LEN_W-1:0] CHIP_BYTES_RESET = 25'd2097152;

    localparam logic [OPC_W-1:0] OP_SECTOR = 8'h20;
    localparam logic [OPC_W-1:0] OP_BLK32 = 8'h52;
    localparam logic [OPC_W-1:0] OP_BLK64 = 8'hD8;
    localparam logic [OPC_W-1:0] OP_CHIP = 8'hC7;
    localparam logic [OPC_W-1:0] OP_PROG = 8'h02;

    typedef enum logic [1:0] {
        CMD_ERASE = 2'd0,
        CMD_CHIP = 2'd1,
        CMD_PROG = 2'd2,
        CMD_STEP = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_ERASE = 3'd0,
        KIND_PROG = 3'd1,
        KIND_CHIP = 3'd2,
        KIND_STEP = 3'd3,
        KIND_DROP = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_ERASE = 3'b010,
        MODE_PROG = 3'b100
    } mode_t;

    typedef struct packed {
        kind_t kind;
        logic step_ok;
        logic [START_W-1:0] start_address;
        logic [LEN_W-1:0] length;
    } entry_t;

endpackage

/* hdl/fepp_front.sv */
// Front end: accepts requests, checks program ranges and classifies them.
// Holds the chip size register. Depends on fepp_pkg.
module fepp_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [fepp_pkg::LEN_W-1:0]          cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [1:0]                          s_tuser,
    input  logic [fepp_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                push_valid,
    input  logic                                push_ready,
    output fepp_pkg::entry_t                    push_data
);

    logic [fepp_pkg::LEN_W-1:0]   chip_bytes_reg;
    logic [fepp_pkg::START_W-1:0] start_address;
    logic [fepp_pkg::LEN_W-1:0]   length;
    logic                         step_ok;
    logic [fepp_pkg::LEN_W:0]     end_address;
    logic                         past_end;
    fepp_pkg::kind_t              kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_bytes_reg <= fepp_pkg::CHIP_BYTES_RESET;
        end else if (cfg_wr_en) begin
            chip_bytes_reg <= cfg_wr_data;
        end
    end

    assign start_address = s_tdata[23:0];
    assign length = s_tdata[48:24];
    assign step_ok = s_tdata[49];

    assign end_address = (fepp_pkg::LEN_W+1)'(start_address) + (fepp_pkg::LEN_W+1)'(length);
    assign past_end = end_address > (fepp_pkg::LEN_W+1)'(chip_bytes_reg);

    always_comb begin
        case (fepp_pkg::cmd_t'(s_tuser))
            fepp_pkg::CMD_ERASE: begin
                kind = (length == '0) ? fepp_pkg::KIND_DROP : fepp_pkg::KIND_ERASE;
            end
            fepp_pkg::CMD_PROG: begin
                kind = (length == '0 || past_end) ? fepp_pkg::KIND_DROP : fepp_pkg::KIND_PROG;
            end
            fepp_pkg::CMD_CHIP: begin
                kind = fepp_pkg::KIND_CHIP;
            end
            default: begin
                kind = fepp_pkg::KIND_STEP;
            end
        endcase
    end

    assign s_tready = push_ready;
    assign push_valid = s_tvalid;
    assign push_data.kind = kind;
    assign push_data.step_ok = step_ok;
    assign push_data.start_address = start_address;
    assign push_data.length = length;

endmodule

/* hdl/fepp_queue.sv */
// Two-entry queue of classified requests between the front and back ends.
// Depends on fepp_pkg for the entry type.
module fepp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  fepp_pkg::entry_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output fepp_pkg::entry_t pop_data
);

    fepp_pkg::entry_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/fepp_back.sv */
// Back end: keeps the request state, plans each device operation and
// holds the result register. Depends on fepp_pkg.
module fepp_back #(
    parameter int ADDR_BITS = fepp_pkg::DEF_ADDR_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               pop_valid,
    output logic                               pop_ready,
    input  fepp_pkg::entry_t                   pop_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fepp_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    localparam int LEN_W = fepp_pkg::LEN_W;

    fepp_pkg::mode_t              mode_reg, mode_next;
    logic [ADDR_BITS-1:0]         addr_reg, addr_next;
    logic [LEN_W-1:0]             left_reg, left_next;

    logic                         out_valid_reg, out_valid_next;
    logic [fepp_pkg::OPC_W-1:0]   opcode_reg, opcode_next;
    logic [23:0]                  op_addr_reg, op_addr_next;
    logic [fepp_pkg::OPB_W-1:0]   op_bytes_reg, op_bytes_next;
    logic                         last_reg, last_next;

    logic                         pop;
    logic                         is_req;
    logic                         busy;
    fepp_pkg::mode_t              cur_mode;
    logic [ADDR_BITS-1:0]         start_ext;
    logic [ADDR_BITS-1:0]         cur_addr;
    logic [LEN_W-1:0]             cur_left;
    logic                         blk64;
    logic                         blk32;
    logic [16:0]                  sec_used;
    logic [8:0]                   page_room;
    logic [8:0]                   prog_used;
    logic [16:0]                  used;
    logic [fepp_pkg::OPC_W-1:0]   plan_op;
    logic                         plan_last;
    logic [LEN_W-1:0]             left_after;
    logic [ADDR_BITS-1:0]         addr_after;

    assign pop_ready = !out_valid_reg || m_tready;
    assign pop = pop_valid && pop_ready;
    assign busy = mode_reg == fepp_pkg::MODE_ERASE || mode_reg == fepp_pkg::MODE_PROG;
    assign is_req = pop_data.kind == fepp_pkg::KIND_ERASE || pop_data.kind == fepp_pkg::KIND_PROG;

    assign start_ext = ADDR_BITS'(32'(pop_data.start_address));
    assign cur_mode = !is_req ? mode_reg
                    : (pop_data.kind == fepp_pkg::KIND_ERASE) ? fepp_pkg::MODE_ERASE
                    : fepp_pkg::MODE_PROG;
    assign cur_addr = is_req ? start_ext : addr_reg;
    assign cur_left = is_req ? pop_data.length : left_reg;

    assign blk64 = cur_addr[15:0] == 16'd0 && cur_left >= 25'd65536;
    assign blk32 = cur_addr[14:0] == 15'd0 && cur_left >= 25'd32768;
    assign sec_used = 17'(13'd4096 - {1'b0, cur_addr[11:0]});
    assign page_room = 9'd256 - {1'b0, cur_addr[7:0]};
    assign prog_used = (LEN_W'(page_room) > cur_left) ? cur_left[8:0] : page_room;

    always_comb begin
        if (cur_mode == fepp_pkg::MODE_PROG) begin
            plan_op = fepp_pkg::OP_PROG;
            used = 17'(prog_used);
        end else if (blk64) begin
            plan_op = fepp_pkg::OP_BLK64;
            used = 17'd65536;
        end else if (blk32) begin
            plan_op = fepp_pkg::OP_BLK32;
            used = 17'd32768;
        end else begin
            plan_op = fepp_pkg::OP_SECTOR;
            used = sec_used;
        end
    end

    assign plan_last = LEN_W'(used) >= cur_left;
    assign left_after = plan_last ? '0 : cur_left - LEN_W'(used);
    assign addr_after = cur_addr + ADDR_BITS'(used);

    always_comb begin
        mode_next = mode_reg;
        addr_next = addr_reg;
        left_next = left_reg;
        out_valid_next = out_valid_reg && !m_tready;
        opcode_next = opcode_reg;
        op_addr_next = op_addr_reg;
        op_bytes_next = op_bytes_reg;
        last_next = last_reg;
        if (pop) begin
            case (pop_data.kind)
                fepp_pkg::KIND_ERASE, fepp_pkg::KIND_PROG, fepp_pkg::KIND_STEP: begin
                    if (is_req || (busy && pop_data.step_ok)) begin
                        mode_next = plan_last ? fepp_pkg::MODE_IDLE : cur_mode;
                        addr_next = addr_after;
                        left_next = left_after;
                        out_valid_next = 1'b1;
                        opcode_next = plan_op;
                        op_addr_next = 24'(32'(cur_addr));
                        op_bytes_next = (cur_mode == fepp_pkg::MODE_PROG) ? prog_used : '0;
                        last_next = plan_last;
                    end else if (busy) begin
                        mode_next = fepp_pkg::MODE_IDLE;
                        left_next = '0;
                    end
                end
                fepp_pkg::KIND_CHIP: begin
                    mode_next = fepp_pkg::MODE_IDLE;
                    left_next = '0;
                    out_valid_next = 1'b1;
                    opcode_next = fepp_pkg::OP_CHIP;
                    op_addr_next = '0;
                    op_bytes_next = '0;
                    last_next = 1'b1;
                end
                default: begin
                    mode_next = fepp_pkg::MODE_IDLE;
                    addr_next = start_ext;
                    left_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= fepp_pkg::MODE_IDLE;
            addr_reg <= '0;
            left_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            addr_reg <= addr_next;
            left_reg <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        opcode_reg <= opcode_next;
        op_addr_reg <= op_addr_next;
        op_bytes_reg <= op_bytes_next;
        last_reg <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {7'd0, op_bytes_reg, op_addr_reg, opcode_reg};
    assign m_tlast = last_reg;

endmodule

/* hdl/flash_erase_program_planner_unit.sv */
// A transaction is registered into the request queue and then into the result register.
// Throughput: one transaction per cycle while the queue has room; the two-entry queue
// lets the front keep accepting while a result waits on m_tready. Reset is synchronous
// and active low: it empties the queue and result register, returns the planner to idle
// and sets chip_bytes to 2 MiB.
// Top level of the flash erase and program planner; depends on fepp_pkg and the fepp modules.
module flash_erase_program_planner_unit #(
    parameter int ADDR_BITS = fepp_pkg::DEF_ADDR_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [fepp_pkg::LEN_W-1:0]      cfg_wr_data,  // chip_bytes
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [1:0]                      s_tuser,      // command
    input  logic [fepp_pkg::S_TDATA_W-1:0]  s_tdata,      // start_address, length, step_ok
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fepp_pkg::M_TDATA_W-1:0]  m_tdata,      // opcode, op_address, op_bytes
    output logic                            m_tlast
);

    logic             push_valid;
    logic             push_ready;
    fepp_pkg::entry_t push_data;
    logic             pop_valid;
    logic             pop_ready;
    fepp_pkg::entry_t pop_data;

    fepp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    fepp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    fepp_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* hdl/fepp_checker.sv */
// Port-level checker for the flash erase and program planner, bound to the top level.
// Depends on fepp_pkg and the assertion macro header.
`include "flash_erase_program_planner_unit_macros.svh"

module fepp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fepp_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);

    logic [9:0] page_end;

    assign page_end = {2'b00, m_tdata[15:8]} + {1'b0, m_tdata[40:32]};

    `FEPP_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result transaction changed")
    `FEPP_ASSERT_SAME(a_chip, aclk, aresetn, m_tvalid && m_tdata[7:0] == fepp_pkg::OP_CHIP, m_tdata[40:8] == 33'd0 && m_tlast, "chip erase without zero fields and last")
    `FEPP_ASSERT_SAME(a_erase_bytes, aclk, aresetn, m_tvalid && m_tdata[7:0] != fepp_pkg::OP_PROG, m_tdata[40:32] == 9'd0, "erase transaction carries a byte count")
    `FEPP_ASSERT_SAME(a_page, aclk, aresetn, m_tvalid && m_tdata[7:0] == fepp_pkg::OP_PROG, m_tdata[40:32] != 9'd0 && page_end <= 10'd256, "page program crosses a page or is empty")

endmodule

bind flash_erase_program_planner_unit fepp_checker u_fepp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* tb/sv/fepp_planner_checker.sv */
`timescale 1ns / 1ps
// Checker for the flash erase and program planner: watches both stream channels and
// the chip_bytes write port, plans the expected flash operations and compares results.
// Depends on fepp_pkg for the command codes, opcodes and field widths.
module fepp_planner_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [fepp_pkg::LEN_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [1:0]                      s_tuser,
    input  logic [fepp_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fepp_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            m_tlast,
    output int                              mismatches,
    output int                              outstanding
);
    import fepp_pkg::*;

    localparam logic [LEN_W-1:0] BLK64_BYTES = 25'd65536;
    localparam logic [LEN_W-1:0] BLK32_BYTES = 25'd32768;
    localparam logic [LEN_W-1:0] SECTOR_BYTES = 25'd4096;
    localparam logic [LEN_W-1:0] PAGE_BYTES = 25'd256;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [OPC_W-1:0]   opcode;
        logic [START_W-1:0] address;
        logic [OPB_W-1:0]   nbytes;
        logic               last;
    } flash_op_t;

    flash_op_t planned_ops[$];
    mode_t plan_mode;
    logic [START_W-1:0] plan_address;
    logic [LEN_W-1:0] plan_bytes_left;
    logic [LEN_W-1:0] plan_chip_bytes;
    int error_count;

    function automatic bit issue_next_op(output flash_op_t op);
        logic [LEN_W-1:0] used;
        logic [OPC_W-1:0] opc;
        logic [OPB_W-1:0] nb;
        logic fin;
        nb = '0;
        op = '0;
        case (plan_mode)
            MODE_ERASE: begin
                if (plan_address[15:0] == 16'd0 && plan_bytes_left >= BLK64_BYTES) begin
                    opc = OP_BLK64;
                    used = BLK64_BYTES;
                end else if (plan_address[14:0] == 15'd0 && plan_bytes_left >= BLK32_BYTES) begin
                    opc = OP_BLK32;
                    used = BLK32_BYTES;
                end else begin
                    opc = OP_SECTOR;
                    used = SECTOR_BYTES - {13'd0, plan_address[11:0]};
                end
            end
            MODE_PROG: begin
                opc = OP_PROG;
                used = PAGE_BYTES - {17'd0, plan_address[7:0]};
                if (used > plan_bytes_left) used = plan_bytes_left;
                nb = used[OPB_W-1:0];
            end
            default: return 1'b0;
        endcase
        fin = (used >= plan_bytes_left);
        plan_bytes_left = fin ? '0 : plan_bytes_left - used;
        op = '{opcode: opc, address: plan_address, nbytes: nb, last: fin};
        plan_address = plan_address + used[START_W-1:0];
        if (fin) plan_mode = MODE_IDLE;
        return 1'b1;
    endfunction

    function automatic bit plan_transaction(input cmd_t cmd, input logic [START_W-1:0] start,
                                            input logic [LEN_W-1:0] len, input logic ok,
                                            output flash_op_t op);
        op = '0;
        case (cmd)
            CMD_ERASE, CMD_PROG: begin
                plan_mode = MODE_IDLE;
                plan_address = start;
                plan_bytes_left = len;
                if (len == '0) return 1'b0;
                if (cmd == CMD_PROG &&
                    ({2'b0, start} + {1'b0, len}) > {1'b0, plan_chip_bytes}) begin
                    plan_bytes_left = '0;
                    return 1'b0;
                end
                plan_mode = (cmd == CMD_ERASE) ? MODE_ERASE : MODE_PROG;
                return issue_next_op(op);
            end
            CMD_CHIP: begin
                plan_mode = MODE_IDLE;
                plan_bytes_left = '0;
                op = '{opcode: OP_CHIP, address: '0, nbytes: '0, last: 1'b1};
                return 1'b1;
            end
            default: begin
                if (plan_mode != MODE_ERASE && plan_mode != MODE_PROG) return 1'b0;
                if (!ok) begin
                    plan_mode = MODE_IDLE;
                    plan_bytes_left = '0;
                    return 1'b0;
                end
                return issue_next_op(op);
            end
        endcase
    endfunction

    initial begin
        error_count = 0;
        mismatches = 0;
        outstanding = 0;
        plan_mode = MODE_IDLE;
        plan_address = '0;
        plan_bytes_left = '0;
        plan_chip_bytes = CHIP_BYTES_RESET;
    end

    always @(posedge aclk) begin
        flash_op_t want;
        flash_op_t got;
        if (!aresetn) begin
            plan_mode = MODE_IDLE;
            plan_address = '0;
            plan_bytes_left = '0;
            plan_chip_bytes = CHIP_BYTES_RESET;
            planned_ops.delete();
        end else begin
            if (cfg_wr_en) plan_chip_bytes = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got = '{opcode: m_tdata[7:0], address: m_tdata[31:8],
                        nbytes: m_tdata[40:32], last: m_tlast};
                if (planned_ops.size() == 0) begin
                    if (error_count < REPORT_LIMIT)
                        $display("%0t: unexpected result opcode=%h addr=%h bytes=%0d last=%b",
                                 $realtime, got.opcode, got.address, got.nbytes, got.last);
                    error_count++;
                end else begin
                    want = planned_ops.pop_front();
                    if (got.opcode !== want.opcode || got.address !== want.address ||
                        got.nbytes !== want.nbytes || got.last !== want.last) begin
                        if (error_count < REPORT_LIMIT)
                            $display("%0t: mismatch expected opcode=%h addr=%h bytes=%0d last=%b, got opcode=%h addr=%h bytes=%0d last=%b",
                                     $realtime, want.opcode, want.address, want.nbytes,
                                     want.last, got.opcode, got.address, got.nbytes,
                                     got.last);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (plan_transaction(cmd_t'(s_tuser), s_tdata[23:0], s_tdata[48:24],
                                     s_tdata[49], want))
                    planned_ops.push_back(want);
            end
        end
        mismatches <= error_count;
        outstanding <= planned_ops.size();
    end

endmodule

/* tb/sv/flash_erase_program_planner_unit_tb.sv */
`timescale 1ns / 1ps
// Top of the flash erase and program planner testbench: clock, reset, stimulus and verdict.
// Depends on fepp_pkg, the planner RTL and fepp_planner_checker.
module flash_erase_program_planner_unit_tb;

    localparam int LEN_W = fepp_pkg::LEN_W;
    localparam int START_W = fepp_pkg::START_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS = 56;
    localparam int NUM_PHASES = 8;
    localparam logic [LEN_W-1:0] MAX_LEN = 25'd16777216;

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [1:0] s_tuser = '0;
    logic [fepp_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [fepp_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tlast;

    int mismatches;
    int outstanding;
    int s_idle_pct = 0;
    int m_stall_pct = 0;
    int cycle_count = 0;
    int items_sent = 0;
    logic [LEN_W-1:0] chip_now = fepp_pkg::CHIP_BYTES_RESET;

    flash_erase_program_planner_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    fepp_planner_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= m_stall_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_item(input fepp_pkg::cmd_t cmd, input logic [START_W-1:0] start,
                             input logic [LEN_W-1:0] len, input logic ok);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {6'd0, ok, len, start};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_steps(input int count, input logic ok);
        repeat (count) send_item(fepp_pkg::CMD_STEP, START_W'($urandom),
                                 LEN_W'($urandom_range(MAX_LEN)), ok);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_chip_bytes(input logic [LEN_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        chip_now = value;
        @(posedge aclk);
    endtask

    task automatic send_request;
        int roll;
        int back;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0] len;
        roll = $urandom_range(99);
        if (roll < 45) begin
            case ($urandom_range(3))
                0: start = START_W'($urandom) & 24'hFFF000;
                1: start = START_W'($urandom) & 24'hFF8000;
                2: start = START_W'($urandom) & 24'hFF0000;
                default: start = START_W'($urandom);
            endcase
            roll = $urandom_range(99);
            if (roll < 70) len = LEN_W'($urandom_range(1, 25'h12000));
            else if (roll < 90) len = LEN_W'($urandom_range(1, 25'h80000));
            else if (roll < 95) len = '0;
            else len = LEN_W'($urandom_range(MAX_LEN));
            send_item(fepp_pkg::CMD_ERASE, start, len, 1'($urandom_range(1)));
        end else if (roll < 85) begin
            if ($urandom_range(99) < 60) begin
                back = $urandom_range(1, 2000);
                if (back > int'(chip_now)) back = int'(chip_now);
                start = START_W'(int'(chip_now) - back);
                len = LEN_W'($urandom_range(1, back + 8));
            end else begin
                start = START_W'($urandom_range(chip_now - 25'd1));
                roll = $urandom_range(99);
                if (roll < 80) len = LEN_W'($urandom_range(1, 1100));
                else if (roll < 90) len = '0;
                else len = LEN_W'($urandom_range(MAX_LEN));
            end
            send_item(fepp_pkg::CMD_PROG, start, len, 1'($urandom_range(1)));
        end else begin
            send_item(fepp_pkg::CMD_CHIP, START_W'($urandom), LEN_W'($urandom_range(MAX_LEN)),
                      1'($urandom_range(1)));
        end
    endtask

    task automatic run_random(input int count);
        int first;
        first = items_sent;
        while (items_sent - first < count) begin
            if ($urandom_range(99) < 8) begin
                send_item(fepp_pkg::cmd_t'($urandom_range(3)), START_W'($urandom),
                          LEN_W'($urandom_range(MAX_LEN)), 1'($urandom_range(1)));
            end else begin
                send_request();
                repeat ($urandom_range(0, 10))
                    send_steps(1, ($urandom_range(19) != 0));
            end
        end
    endtask

    task automatic run_directed;
        send_steps(1, 1'b1);
        send_item(fepp_pkg::CMD_ERASE, 24'h000000, 25'd0, 1'b1);
        send_item(fepp_pkg::CMD_PROG, 24'h000100, 25'd0, 1'b1);
        send_item(fepp_pkg::CMD_ERASE, 24'h00F800, 25'h30000, 1'b1);
        send_steps(6, 1'b1);
        send_item(fepp_pkg::CMD_ERASE, 24'hFFF800, 25'h2000, 1'b0);
        send_steps(2, 1'b1);
        send_item(fepp_pkg::CMD_CHIP, 24'hFFFFFF, MAX_LEN, 1'b1);
        send_item(fepp_pkg::CMD_PROG, 24'h0001F0, 25'h220, 1'b1);
        send_steps(3, 1'b1);
        send_item(fepp_pkg::CMD_PROG, START_W'(chip_now - 25'd256), 25'd256, 1'b1);
        send_item(fepp_pkg::CMD_PROG, START_W'(chip_now - 25'd256), 25'd257, 1'b1);
        send_item(fepp_pkg::CMD_PROG, 24'hFFFFFF, 25'd1, 1'b1);
        send_item(fepp_pkg::CMD_PROG, 24'h000000, 25'h1000, 1'b1);
        send_steps(1, 1'b1);
        send_steps(1, 1'b0);
        send_steps(1, 1'b1);
        send_item(fepp_pkg::CMD_ERASE, 24'h000000, MAX_LEN, 1'b1);
        send_steps(2, 1'b1);
        send_item(fepp_pkg::CMD_PROG, 24'h000080, 25'd300, 1'b1);
        send_steps(2, 1'b1);
    endtask

    initial begin
        logic [LEN_W-1:0] chip_values [NUM_PHASES];
        chip_values = '{25'd4096, MAX_LEN, 25'd0, fepp_pkg::CHIP_BYTES_RESET,
                        MAX_LEN, 25'd4096, 25'd0, 25'd0};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        drain();
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 4)
                0: begin s_idle_pct = 0; m_stall_pct = 0; end
                1: begin s_idle_pct = 74; m_stall_pct = 0; end
                2: begin s_idle_pct = 0; m_stall_pct = 74; end
                default: begin s_idle_pct = 11; m_stall_pct = 11; end
            endcase
            if (chip_values[phase] == '0)
                write_chip_bytes(LEN_W'($urandom_range(4096, MAX_LEN)));
            else write_chip_bytes(chip_values[phase]);
            run_random(PHASE_ITEMS);
            drain();
        end
        if (mismatches == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/fepp_pkg.sv
hdl/fepp_front.sv
hdl/fepp_queue.sv
hdl/fepp_back.sv
hdl/flash_erase_program_planner_unit.sv
hdl/fepp_checker.sv
tb/sv/fepp_planner_checker.sv
tb/sv/flash_erase_program_planner_unit_tb.sv
